// ----- rtl/ossp_pkg.sv -----
// ----------------------------------------------------------------------------
// ossp_pkg
// Shared constants and codes for the one-shot sample player.
// ----------------------------------------------------------------------------
package ossp_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int ADDR_W     = 16;
    localparam int DEPTH      = 1 << ADDR_W;
    localparam int COUNT_W    = ADDR_W + 1;
    localparam int POS_W      = COUNT_W + FRAC_BITS;
    localparam int SAMPLE_W   = 32;
    localparam int RAW_W      = 16;
    localparam int STEP_W     = 24;
    localparam int LEVEL_W    = 31;
    localparam int CFG_W      = 31;
    localparam int PROD_W     = SAMPLE_W + LEVEL_W;
    localparam int DIV_STEPS  = SAMPLE_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [2:0] OP_CLEAR     = 3'd0;
    localparam logic [2:0] OP_LOAD      = 3'd1;
    localparam logic [2:0] OP_TICK      = 3'd2;
    localparam logic [2:0] OP_RESTART   = 3'd3;
    localparam logic [2:0] OP_NORMALIZE = 3'd4;

    localparam logic REG_STEP_RATE  = 1'b0;
    localparam logic REG_PEAK_LEVEL = 1'b1;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [PROD_W-1:0]   prod_t;

endpackage

// ----- rtl/one_shot_sample_player.sv -----
// ----------------------------------------------------------------------------
// one_shot_sample_player
// One-shot sample player: Q16.16 sample store, fractional playback, normalize.
// ----------------------------------------------------------------------------
// Input channel: operation and sample_in transfer when in_valid is high and
// in_stall is low. Each operation gives exactly one result on the output
// channel (sample_out, done_res, rejected), which transfers when out_valid is
// high and out_stall is low.
// in_stall is high while an operation is in progress; one operation at a time.
// Path from input transfer to out_valid:
//   clear, load, restart, unused codes: straight to completion
//   tick: one read of the single-port sample memory
//   normalize with N samples: peak scan, then, for a nonzero peak, a rescale
//   of each sample through the divider (one quotient bit a cycle)
// A result waiting on out_stall does not block the next input transfer; the
// block holds its following result until the output register is free.
// Reset clears count, position, held output and loads step_rate = 1.0 and
// peak_level = 1.0. Sample memory contents are undefined until loaded.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
// the user must issue them only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module one_shot_sample_player
    import ossp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [2:0]           operation,
    input  logic signed [RAW_W-1:0] sample_in,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                 done_res,
    output logic                 rejected
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_TICK_RD  = 4'd1;
    localparam logic [3:0] S_TICK_WB  = 4'd2;
    localparam logic [3:0] S_PK_RD    = 4'd3;
    localparam logic [3:0] S_PK_CMP   = 4'd4;
    localparam logic [3:0] S_NM_RD    = 4'd5;
    localparam logic [3:0] S_NM_MUL   = 4'd6;
    localparam logic [3:0] S_NM_START = 4'd7;
    localparam logic [3:0] S_NM_DIV   = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    function automatic sample_t mag32(input sample_t v);
        return v[SAMPLE_W-1] ? (~v + sample_t'(1)) : v;
    endfunction

    logic [3:0]          state_reg, state_next;
    logic [STEP_W-1:0]   step_rate_reg;
    logic [LEVEL_W-1:0]  peak_level_reg;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    sample_t             held_reg, held_next;
    logic                flag_done_reg, flag_done_next;
    logic                flag_rej_reg, flag_rej_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    sample_t             peak_reg, peak_next;
    prod_t               prod_reg, prod_next;
    logic                sign_reg, sign_next;
    logic                out_valid_reg;
    sample_t             sample_out_reg;
    logic                done_out_reg, rej_out_reg;

    sample_t             store_mem [DEPTH];
    sample_t             mem_rdata_reg;
    logic [ADDR_W-1:0]   mem_addr;
    logic                mem_we;
    sample_t             mem_wdata;

    logic                accept;
    logic                emit;
    logic                last_idx;
    logic [POS_W-1:0]    pos_sum;
    logic [POS_W-1:0]    end_pos;
    logic [POS_W-1:0]    last_pos;
    sample_t             rd_mag;
    logic                div_start;
    logic                div_done;
    sample_t             div_quo;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign emit     = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign last_idx = (COUNT_W'(idx_reg) + COUNT_W'(1)) == count_reg;
    assign pos_sum  = pos_reg + POS_W'(step_rate_reg);
    assign end_pos  = {count_reg, {FRAC_BITS{1'b0}}};
    assign last_pos = {count_reg - COUNT_W'(1), {FRAC_BITS{1'b0}}};
    assign rd_mag   = mag32(mem_rdata_reg);
    assign div_start = (state_reg == S_NM_START);

    ossp_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (peak_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        held_next      = held_reg;
        flag_done_next = flag_done_reg;
        flag_rej_next  = flag_rej_reg;
        idx_next       = idx_reg;
        peak_next      = peak_reg;
        prod_next      = prod_reg;
        sign_next      = sign_reg;
        mem_addr       = idx_reg;
        mem_we         = 1'b0;
        mem_wdata      = sign_reg ? (~div_quo + sample_t'(1)) : div_quo;
        unique case (state_reg)
            S_IDLE:
            begin
                mem_addr  = count_reg[ADDR_W-1:0];
                mem_wdata = sample_t'(signed'(sample_in)) << FRAC_BITS;
                if (accept)
                begin
                    flag_done_next = 1'b0;
                    flag_rej_next  = 1'b0;
                    state_next     = S_DONE;
                    case (operation)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            pos_next   = '0;
                        end
                        OP_LOAD:
                        begin
                            if (count_reg[ADDR_W])
                            begin
                                flag_rej_next = 1'b1;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        OP_TICK:
                        begin
                            if (count_reg == '0)
                            begin
                                pos_next       = '0;
                                held_next      = '0;
                                flag_done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_TICK_RD;
                                if (pos_sum >= end_pos)
                                begin
                                    pos_next       = last_pos;
                                    flag_done_next = 1'b1;
                                end
                                else
                                begin
                                    pos_next = pos_sum;
                                end
                            end
                        end
                        OP_RESTART:
                        begin
                            pos_next  = '0;
                            held_next = '0;
                        end
                        OP_NORMALIZE:
                        begin
                            idx_next  = '0;
                            peak_next = '0;
                            if (count_reg != '0)
                            begin
                                state_next = S_PK_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_TICK_RD:
            begin
                mem_addr   = pos_reg[FRAC_BITS +: ADDR_W];
                state_next = S_TICK_WB;
            end
            S_TICK_WB:
            begin
                held_next  = mem_rdata_reg;
                state_next = S_DONE;
            end
            S_PK_RD:
            begin
                state_next = S_PK_CMP;
            end
            S_PK_CMP:
            begin
                if (rd_mag > peak_reg)
                begin
                    peak_next = rd_mag;
                end
                if (last_idx)
                begin
                    idx_next   = '0;
                    state_next = (peak_next == '0) ? S_DONE : S_NM_RD;
                end
                else
                begin
                    idx_next   = idx_reg + ADDR_W'(1);
                    state_next = S_PK_RD;
                end
            end
            S_NM_RD:
            begin
                state_next = S_NM_MUL;
            end
            S_NM_MUL:
            begin
                prod_next  = PROD_W'(rd_mag) * PROD_W'(peak_level_reg);
                sign_next  = mem_rdata_reg[SAMPLE_W-1];
                state_next = S_NM_START;
            end
            S_NM_START:
            begin
                state_next = S_NM_DIV;
            end
            S_NM_DIV:
            begin
                if (div_done)
                begin
                    mem_we = 1'b1;
                    if (last_idx)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = S_NM_RD;
                    end
                end
            end
            S_DONE:
            begin
                if (emit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= store_mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_rate_reg  <= STEP_W'(65536);
            peak_level_reg <= LEVEL_W'(65536);
            count_reg      <= '0;
            pos_reg        <= '0;
            held_reg       <= '0;
            flag_done_reg  <= 1'b0;
            flag_rej_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            held_reg      <= held_next;
            flag_done_reg <= flag_done_next;
            flag_rej_reg  <= flag_rej_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_STEP_RATE:  step_rate_reg  <= cfg_data[STEP_W-1:0];
                    REG_PEAK_LEVEL: peak_level_reg <= cfg_data[LEVEL_W-1:0];
                    default:        step_rate_reg  <= step_rate_reg;
                endcase
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        peak_reg <= peak_next;
        prod_reg <= prod_next;
        sign_reg <= sign_next;
        if (emit)
        begin
            sample_out_reg <= held_reg;
            done_out_reg   <= flag_done_reg;
            rej_out_reg    <= flag_rej_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign done_res   = done_out_reg;
    assign rejected   = rej_out_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted operation did not start");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result issued outside completion");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(DEPTH))
        else $error("sample count beyond store depth");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (pos_reg < end_pos))
        else $error("play position past end of sound");

    a_no_stall_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && out_valid_reg && out_stall |=> (state_reg == S_DONE))
        else $error("result dropped while output stalled");

endmodule

// ----- rtl/ossp_div.sv -----
// ----------------------------------------------------------------------------
// ossp_div
// Restoring divider, one quotient bit per cycle; quotient must fit 32 bits.
// ----------------------------------------------------------------------------
module ossp_div
    import ossp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  prod_t   dividend,
    input  sample_t divisor,
    output logic    done,
    output sample_t quotient
);

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    sample_t              rem_reg, rem_next;
    sample_t              quo_reg, quo_next;
    logic                 done_reg, done_next;
    logic [SAMPLE_W:0]    trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[SAMPLE_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = DIV_CNT_W'(DIV_STEPS);
            rem_next = {1'b0, dividend[PROD_W-1:SAMPLE_W]};
            quo_next = dividend[SAMPLE_W-1:0];
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = fits ? SAMPLE_W'(trial - {1'b0, divisor}) : trial[SAMPLE_W-1:0];
            quo_next = {quo_reg[SAMPLE_W-2:0], fits};
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_done_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(cnt_reg == DIV_CNT_W'(1)))
        else $error("divider done without final step");

    a_start_loads_count: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (cnt_reg == DIV_CNT_W'(DIV_STEPS)))
        else $error("divider start did not load step count");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) && !$past(start) && !start |-> rem_reg < divisor)
        else $error("divider remainder out of range");

endmodule

// ----- dv/tb_one_shot_sample_player.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_one_shot_sample_player
// Self-checking bench for the one-shot sample player. Drives clear, load,
// tick, restart, normalize and spare codes through the valid/stall channel,
// tracks store, count, play position and held output in a local predictor,
// and compares every result transfer field by field in order. Covers the
// empty store, end of sound, register extremes and random traffic under
// three idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_one_shot_sample_player;
    import ossp_pkg::*;

    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int NORM_MAX_COUNT = 48;

    typedef struct packed {
        sample_t sample;
        logic    done;
        logic    rejected;
    } player_out_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic                           cfg_index;
    logic [CFG_W-1:0]               cfg_data;
    logic                           in_valid;
    logic                           in_stall;
    logic [2:0]                     operation;
    logic signed [RAW_W-1:0]        sample_in;
    logic                           out_valid;
    logic                           out_stall;
    logic signed [SAMPLE_W-1:0]     sample_out;
    logic                           done_res;
    logic                           rejected;

    sample_t                        sample_mem [DEPTH];
    logic [COUNT_W-1:0]             mem_count;
    logic [POS_W-1:0]               play_pos;
    sample_t                        held_sample;
    logic [STEP_W-1:0]              step_cfg;
    logic [LEVEL_W-1:0]             level_cfg;

    player_out_t                    awaited_outputs [$];
    int                             mismatch_count;
    int                             quiet_cycles;
    int                             items_sent;
    int                             send_idle_pct;
    int                             recv_stall_pct;

    one_shot_sample_player dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .done_res   (done_res),
        .rejected   (rejected)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] magnitude(input sample_t v);
        sample_t neg;
        neg = ~v + 1'b1;
        return v[SAMPLE_W-1] ? {32'h0, neg} : {32'h0, v};
    endfunction

    function automatic player_out_t play_operation(input logic [2:0] op,
                                                   input logic [RAW_W-1:0] raw);
        player_out_t      res;
        logic [POS_W:0]   advanced;
        logic [63:0]      peak;
        logic [63:0]      mag;
        logic [63:0]      scaled;
        logic [31:0]      quot;
        sample_t          s;
        res.done     = 1'b0;
        res.rejected = 1'b0;
        case (op)
            OP_CLEAR:
            begin
                mem_count = '0;
                play_pos  = '0;
            end
            OP_LOAD:
            begin
                if (mem_count >= DEPTH)
                    res.rejected = 1'b1;
                else
                begin
                    sample_mem[mem_count[ADDR_W-1:0]] = {raw, {FRAC_BITS{1'b0}}};
                    mem_count = mem_count + 1'b1;
                end
            end
            OP_TICK:
            begin
                if (mem_count == 0)
                begin
                    play_pos    = '0;
                    held_sample = '0;
                    res.done    = 1'b1;
                end
                else
                begin
                    advanced = play_pos + step_cfg;
                    if (advanced >= ((POS_W+1)'(mem_count) << FRAC_BITS))
                    begin
                        play_pos = POS_W'(mem_count - 1) << FRAC_BITS;
                        res.done = 1'b1;
                    end
                    else
                        play_pos = advanced[POS_W-1:0];
                    held_sample = sample_mem[play_pos[FRAC_BITS +: ADDR_W]];
                end
            end
            OP_RESTART:
            begin
                play_pos    = '0;
                held_sample = '0;
            end
            OP_NORMALIZE:
            begin
                peak = '0;
                for (int i = 0; i < mem_count; i++)
                begin
                    mag = magnitude(sample_mem[i]);
                    if (mag > peak)
                        peak = mag;
                end
                if (peak != 0)
                begin
                    for (int i = 0; i < mem_count; i++)
                    begin
                        s      = sample_mem[i];
                        scaled = (magnitude(s) * level_cfg) / peak;
                        quot   = scaled[31:0];
                        sample_mem[i] = s[SAMPLE_W-1] ? (~quot + 1'b1) : quot;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.sample = held_sample;
        return res;
    endfunction

    always @(posedge clk)
    begin
        player_out_t exp_out;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_outputs.size() == 0)
                begin
                    $display("%0t: unexpected result, actual sample_out %h done %b rejected %b",
                             $time, sample_out, done_res, rejected);
                    mismatch_count++;
                end
                else
                begin
                    exp_out = awaited_outputs.pop_front();
                    if (sample_out !== exp_out.sample)
                    begin
                        $display("%0t: sample_out expected %h actual %h",
                                 $time, exp_out.sample, sample_out);
                        mismatch_count++;
                    end
                    if (done_res !== exp_out.done)
                    begin
                        $display("%0t: done_res expected %b actual %b",
                                 $time, exp_out.done, done_res);
                        mismatch_count++;
                    end
                    if (rejected !== exp_out.rejected)
                    begin
                        $display("%0t: rejected expected %b actual %b",
                                 $time, exp_out.rejected, rejected);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                awaited_outputs.push_back(play_operation(operation, sample_in));
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_item(input logic [2:0] op, input logic [RAW_W-1:0] raw);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        sample_in <= raw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_until_idle;
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_outputs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [CFG_W-1:0] data);
        wait_until_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_STEP_RATE)
            step_cfg = data[STEP_W-1:0];
        else
            level_cfg = data[LEVEL_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [RAW_W-1:0] random_raw();
        case ($urandom_range(19))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return RAW_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] random_step();
        case ($urandom_range(9))
            0:       return '0;
            1:       return CFG_W'(24'hFFFFFF);
            2:       return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(1, 32'h30000));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] random_level();
        case ($urandom_range(7))
            0:       return '0;
            1:       return 31'h7FFFFFFF;
            2:       return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(1, 32'h00100000));
        endcase
    endfunction

    // hold normalize to short stores so each scan stays brief
    function automatic logic [2:0] guarded_op(input logic [2:0] op);
        if (op == OP_NORMALIZE && mem_count > NORM_MAX_COUNT)
            return OP_TICK;
        return op;
    endfunction

    function automatic logic [2:0] pick_sequence_op();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return OP_TICK;
        else if (pick < 72)
            return OP_RESTART;
        else if (pick < 82)
            return OP_LOAD;
        else if (pick < 89)
            return guarded_op(OP_NORMALIZE);
        else if (pick < 94)
            return OP_CLEAR;
        return 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
    endfunction

    task automatic test_empty_store;
        send_item(OP_TICK, 16'h0000);
        send_item(OP_RESTART, 16'hFFFF);
        send_item(OP_SPARE_5, 16'hFFFF);
        send_item(OP_SPARE_6, 16'h0000);
        send_item(OP_SPARE_7, 16'hFFFF);
    endtask

    task automatic test_load_and_play;
        send_item(OP_LOAD, 16'h8000);
        send_item(OP_LOAD, 16'h7FFF);
        send_item(OP_LOAD, 16'hFFFF);
        send_item(OP_LOAD, 16'h0001);
        repeat (5) send_item(OP_TICK, 16'h0000);
        send_item(OP_RESTART, 16'h0000);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_CLEAR, 16'h0000);
    endtask

    task automatic test_step_extremes;
        send_item(OP_LOAD, 16'h1234);
        send_item(OP_LOAD, 16'hEDCB);
        send_item(OP_LOAD, 16'h0000);
        write_register(REG_STEP_RATE, '0);
        send_item(OP_TICK, 16'h0000);
        write_register(REG_STEP_RATE, 31'h7FFFFFFF);
        send_item(OP_TICK, 16'h0000);
        write_register(REG_STEP_RATE, CFG_W'(32'h8000));
        send_item(OP_RESTART, 16'h0000);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_TICK, 16'h0000);
    endtask

    task automatic test_normalize_cases;
        send_item(OP_CLEAR, 16'h0000);
        send_item(OP_LOAD, 16'h0000);
        send_item(OP_LOAD, 16'h0000);
        send_item(OP_NORMALIZE, 16'h0000);
        send_item(OP_LOAD, 16'h8000);
        send_item(OP_LOAD, 16'h4001);
        write_register(REG_PEAK_LEVEL, 31'h7FFFFFFF);
        send_item(OP_NORMALIZE, 16'h0000);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_TICK, 16'h0000);
        write_register(REG_PEAK_LEVEL, '0);
        send_item(OP_NORMALIZE, 16'h0000);
        send_item(OP_TICK, 16'h0000);
        write_register(REG_PEAK_LEVEL, CFG_W'(32'h10000));
    endtask

    task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                       input int item_goal);
        int first_item;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        first_item     = items_sent;
        while (items_sent - first_item < item_goal)
        begin
            if ($urandom_range(99) < 15)
            begin
                if ($urandom_range(1))
                    write_register(REG_STEP_RATE, random_step());
                else
                    write_register(REG_PEAK_LEVEL, random_level());
            end
            if ($urandom_range(99) < 15)
            begin
                repeat ($urandom_range(1, 6))
                    send_item(guarded_op(3'($urandom_range(7))), random_raw());
            end
            else
            begin
                send_item(OP_CLEAR, random_raw());
                repeat ($urandom_range(1, 20)) send_item(OP_LOAD, random_raw());
                repeat ($urandom_range(1, 30)) send_item(pick_sequence_op(), random_raw());
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_STEP_RATE;
        cfg_data       = '0;
        in_valid       = 1'b0;
        operation      = OP_CLEAR;
        sample_in      = '0;
        mem_count      = '0;
        play_pos       = '0;
        held_sample    = '0;
        step_cfg       = STEP_W'(32'h10000);
        level_cfg      = LEVEL_W'(32'h10000);
        mismatch_count = 0;
        quiet_cycles   = 0;
        items_sent     = 0;
        send_idle_pct  = 24;
        recv_stall_pct = 59;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_store();
        test_load_and_play();
        test_step_extremes();
        test_normalize_cases();
        test_random_traffic(24, 59, 383);
        test_random_traffic(59, 24, 383);
        test_random_traffic(0, 0, 384);

        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
